// ===== hw/rtl/tpmq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpmq_pkg
// shared widths, defaults, opcodes, table row type and max helper for tree_path_max_query
// ----------------------------------------------------------------------------
package tpmq_pkg;

	localparam int NODE_W          = 10;
	localparam int WEIGHT_W        = 32;
	localparam int MAX_NODES_DEF   = 1024;
	localparam int LEVELS_DEF      = 10;

	typedef enum logic {
		OP_ADD   = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	// one lifting table entry: 2^i-th ancestor and max weight over those edges
	typedef struct packed {
		logic [NODE_W-1:0]   node;
		logic [WEIGHT_W-1:0] weight;
	} row_t;

	function automatic logic [WEIGHT_W-1:0] max_w(input logic [WEIGHT_W-1:0] x,
		input logic [WEIGHT_W-1:0] y);
		return (x > y) ? x : y;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tree_path_max_query.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tree_path_max_query
// binary-lifting forest with lowest common ancestor and path maximum queries
// ----------------------------------------------------------------------------
//  channel  | signals                                        | transfer when
//  ---------+------------------------------------------------+----------------
//  command  | start, busy, op, first_node, second_node,      | start & !busy
//           | edge_weight                                    |
//  result   | done, common_ancestor, path_maximum,           | done (one cycle)
//           | disconnected                                   |
//
//  one item at a time; every command gives exactly one result
//  add: depth lookups, then a serial read-modify-write of the table for each of
//    levels 1..LEVELS-1
//  query: every lifting step waits on the registered read of the table
//  after reset a clearing pass zeroes the depth memory, with busy high
//  the receiver cannot stall: a result is shown for exactly one cycle
// ----------------------------------------------------------------------------
module tree_path_max_query #(
	parameter int MAX_NODES = tpmq_pkg::MAX_NODES_DEF,
	parameter int LEVELS    = tpmq_pkg::LEVELS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          op,
	input  wire logic [tpmq_pkg::NODE_W-1:0]   first_node,
	input  wire logic [tpmq_pkg::NODE_W-1:0]   second_node,
	input  wire logic [tpmq_pkg::WEIGHT_W-1:0] edge_weight,
	output logic                               done,
	output logic [tpmq_pkg::NODE_W-1:0]        common_ancestor,
	output logic [tpmq_pkg::WEIGHT_W-1:0]      path_maximum,
	output logic                               disconnected
);
	import tpmq_pkg::*;

	localparam int NIW       = $clog2(MAX_NODES);          // node index bits
	localparam int XW        = (NIW > NODE_W) ? NIW : NODE_W;
	localparam int DW        = NIW;                        // depth bits
	localparam int LW        = $clog2(LEVELS);             // level bits
	localparam int RW        = ((DW > LEVELS) ? DW : LEVELS) + 1;
	localparam int TBL_DEPTH = MAX_NODES << LW;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_DEP, S_CHK, S_A_RD, S_A_WR,
		S_Q1, S_Q1_USE, S_Q1_END, S_Q2_RD, S_Q2_USE, S_Q2_END, S_Q3_RD, S_Q3_USE
	} state_t;

	state_t                state_q;
	logic [NIW-1:0]        clr_q;
	op_t                   op_q;
	logic [NODE_W-1:0]     a_q;        // added node, or climbing query node
	logic [NODE_W-1:0]     b_q;        // parent / walking ancestor, or second node
	logic [WEIGHT_W-1:0]   w_q;
	logic [WEIGHT_W-1:0]   res_q;      // running maximum
	logic [DW-1:0]         d1_q;
	logic [DW-1:0]         rem_q;      // depth gap still to climb
	logic [LW-1:0]         lev_q;

	// memories
	row_t                  tbl_mem [TBL_DEPTH];
	logic [DW-1:0]         dep_mem [MAX_NODES];
	row_t                  tbl_rd_a_q, tbl_rd_b_q;
	logic [DW-1:0]         dep_rd_q;

	logic [NIW+LW-1:0]     tbl_raddr_a, tbl_raddr_b, tbl_waddr;
	logic                  tbl_we;
	row_t                  tbl_wdata;
	logic [NIW-1:0]        dep_raddr, dep_waddr;
	logic                  dep_we;
	logic [DW-1:0]         dep_wdata;

	function automatic logic [NIW-1:0] node_idx(input logic [NODE_W-1:0] n);
		logic [XW-1:0] x;
		x = XW'(n);
		return x[NIW-1:0];
	endfunction

	function automatic logic in_range(input logic [NODE_W-1:0] n);
		return int'(n) < MAX_NODES;
	endfunction

	// climb step helpers
	logic [RW-1:0]         pow_x, rem_x;
	logic                  step_take;
	assign pow_x     = RW'(1) << lev_q;
	assign rem_x     = RW'(rem_q);
	assign step_take = rem_x >= pow_x;

	// add and query checks and new row values
	logic                  add_ok, qry_ok;
	logic                  mid_zero;
	row_t                  mid_row;
	assign add_ok = (a_q != '0) && in_range(a_q) && (d1_q == '0) && (b_q != a_q)
		&& in_range(b_q) && ((b_q == '0) || (dep_rd_q != '0));
	assign qry_ok = (a_q != '0) && in_range(a_q) && (b_q != '0) && in_range(b_q)
		&& (d1_q != '0) && (dep_rd_q != '0);
	// node 0 is never written: its row reads as zero
	assign mid_zero = (b_q == '0);
	assign mid_row  = mid_zero ? '0 : tbl_rd_a_q;

	// memory port control
	always_comb begin
		tbl_raddr_a = {node_idx(a_q), lev_q};
		tbl_raddr_b = {node_idx(b_q), lev_q};
		tbl_we      = 1'b0;
		tbl_waddr   = {node_idx(a_q), lev_q};
		tbl_wdata   = '0;
		dep_raddr   = node_idx(b_q);
		dep_we      = 1'b0;
		dep_waddr   = node_idx(a_q);
		dep_wdata   = (b_q == '0) ? DW'(1) : dep_rd_q + DW'(1);
		case (state_q)
			S_CLEAR: begin
				dep_we    = 1'b1;
				dep_waddr = clr_q;
				dep_wdata = '0;
			end
			S_IDLE: dep_raddr = node_idx(first_node);
			S_CHK: begin
				if (op_q == OP_ADD && add_ok) begin
					dep_we         = 1'b1;
					tbl_we         = 1'b1;
					tbl_waddr      = {node_idx(a_q), LW'(0)};
					tbl_wdata.node = b_q;
					tbl_wdata.weight = (b_q == '0) ? '0 : w_q;
				end
			end
			S_A_RD: tbl_raddr_a = {node_idx(b_q), lev_q - LW'(1)};
			S_A_WR: begin
				tbl_we           = 1'b1;
				tbl_wdata.node   = mid_row.node;
				tbl_wdata.weight = max_w(res_q, mid_row.weight);
			end
			S_Q3_RD: begin
				tbl_raddr_a = {node_idx(a_q), LW'(0)};
				tbl_raddr_b = {node_idx(b_q), LW'(0)};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		tbl_rd_a_q <= tbl_mem[tbl_raddr_a];
		tbl_rd_b_q <= tbl_mem[tbl_raddr_b];
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
	end

	always_ff @(posedge clk) begin
		dep_rd_q <= dep_mem[dep_raddr];
		if (dep_we) begin
			dep_mem[dep_waddr] <= dep_wdata;
		end
	end

	assign busy = (state_q != S_IDLE);

	// sequencer with registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NIW'(1);
					if (clr_q == NIW'(MAX_NODES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q    <= op_t'(op);
						a_q     <= first_node;
						b_q     <= second_node;
						w_q     <= edge_weight;
						state_q <= S_DEP;
					end
				end
				S_DEP: begin
					d1_q    <= dep_rd_q;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (op_q == OP_ADD) begin
						if (add_ok) begin
							res_q   <= (b_q == '0) ? '0 : w_q;
							lev_q   <= LW'(1);
							state_q <= S_A_RD;
						end else begin
							done            <= 1'b1;
							common_ancestor <= '0;
							path_maximum    <= '0;
							disconnected    <= 1'b0;
							state_q         <= S_IDLE;
						end
					end else if (!qry_ok) begin
						done            <= 1'b1;
						common_ancestor <= '0;
						path_maximum    <= '0;
						disconnected    <= 1'b1;
						state_q         <= S_IDLE;
					end else begin
						// deeper node climbs first
						if (d1_q < dep_rd_q) begin
							a_q   <= b_q;
							b_q   <= a_q;
							rem_q <= dep_rd_q - d1_q;
						end else begin
							rem_q <= d1_q - dep_rd_q;
						end
						res_q   <= '0;
						lev_q   <= LW'(LEVELS - 1);
						state_q <= S_Q1;
					end
				end
				S_A_RD: state_q <= S_A_WR;
				S_A_WR: begin
					b_q   <= mid_row.node;
					res_q <= max_w(res_q, mid_row.weight);
					if (lev_q == LW'(LEVELS - 1)) begin
						done            <= 1'b1;
						common_ancestor <= '0;
						path_maximum    <= '0;
						disconnected    <= 1'b0;
						state_q         <= S_IDLE;
					end else begin
						lev_q   <= lev_q + LW'(1);
						state_q <= S_A_RD;
					end
				end
				S_Q1: begin
					if (step_take) begin
						state_q <= S_Q1_USE;
					end else if (lev_q == '0) begin
						state_q <= S_Q1_END;
					end else begin
						lev_q <= lev_q - LW'(1);
					end
				end
				S_Q1_USE: begin
					a_q   <= tbl_rd_a_q.node;
					res_q <= max_w(res_q, tbl_rd_a_q.weight);
					rem_q <= DW'(rem_x - pow_x);
					if (lev_q == '0) begin
						state_q <= S_Q1_END;
					end else begin
						lev_q   <= lev_q - LW'(1);
						state_q <= S_Q1;
					end
				end
				S_Q1_END, S_Q2_END: begin
					if (a_q == b_q) begin
						done            <= 1'b1;
						common_ancestor <= a_q;
						path_maximum    <= res_q;
						disconnected    <= 1'b0;
						state_q         <= S_IDLE;
					end else if (state_q == S_Q1_END) begin
						lev_q   <= LW'(LEVELS - 1);
						state_q <= S_Q2_RD;
					end else begin
						state_q <= S_Q3_RD;
					end
				end
				S_Q2_RD: state_q <= S_Q2_USE;
				S_Q2_USE: begin
					if (tbl_rd_a_q.node != tbl_rd_b_q.node) begin
						res_q <= max_w(res_q, max_w(tbl_rd_a_q.weight, tbl_rd_b_q.weight));
						a_q   <= tbl_rd_a_q.node;
						b_q   <= tbl_rd_b_q.node;
					end
					if (lev_q == '0) begin
						state_q <= S_Q2_END;
					end else begin
						lev_q   <= lev_q - LW'(1);
						state_q <= S_Q2_RD;
					end
				end
				S_Q3_RD: state_q <= S_Q3_USE;
				S_Q3_USE: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
					// separate roots meet only at node 0
					if (tbl_rd_a_q.node == '0) begin
						common_ancestor <= '0;
						path_maximum    <= '0;
						disconnected    <= 1'b1;
					end else begin
						common_ancestor <= tbl_rd_a_q.node;
						path_maximum    <= max_w(res_q,
							max_w(tbl_rd_a_q.weight, tbl_rd_b_q.weight));
						disconnected    <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// checks
	a_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in flight");

	a_add_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == OP_ADD) |-> (common_ancestor == '0 && path_maximum == '0
			&& !disconnected))
		else $error("add result not all zero");

	a_disc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && disconnected) |-> (common_ancestor == '0 && path_maximum == '0))
		else $error("disconnected result carries data");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transfer accepted but block not busy");

endmodule
`default_nettype wire

// ===== tb/tree_path_max_query_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_path_max_query_test
// self-checking bench: builds random weighted forests through add commands,
// asks lowest common ancestor / path maximum queries and compares every
// result against a behavioral binary-lifting model kept in the bench
// ----------------------------------------------------------------------------
module tree_path_max_query_test;
	import tpmq_pkg::*;

	localparam int NODES      = MAX_NODES_DEF;
	localparam int LVLS       = LEVELS_DEF;
	localparam int CYCLE_CAP  = 1000000;

	typedef struct {
		logic [NODE_W-1:0]   lca;
		logic [WEIGHT_W-1:0] pmax;
		logic                disc;
	} answer_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                op = 1'b0;
	logic [NODE_W-1:0]   first_node = '0;
	logic [NODE_W-1:0]   second_node = '0;
	logic [WEIGHT_W-1:0] edge_weight = '0;
	logic                busy;
	logic                done;
	logic [NODE_W-1:0]   common_ancestor;
	logic [WEIGHT_W-1:0] path_maximum;
	logic                disconnected;

	// model of the lifting tables
	logic [NODE_W-1:0]   lift_parent [NODES][LVLS];
	logic [WEIGHT_W-1:0] lift_max [NODES][LVLS];
	int                  depth_of [NODES];

	answer_t             pending_answers [$];
	int                  placed_nodes [$];
	int                  free_nodes [$];
	logic                busy_seen = 1'b1;
	bit                  failed = 1'b0;
	int                  cycles = 0;

	tree_path_max_query uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.first_node(first_node), .second_node(second_node),
		.edge_weight(edge_weight), .done(done), .common_ancestor(common_ancestor),
		.path_maximum(path_maximum), .disconnected(disconnected)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// cap on run length, covers the depth clearing pass after reset too
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_CAP) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [WEIGHT_W-1:0] wmax(logic [WEIGHT_W-1:0] x,
		logic [WEIGHT_W-1:0] y);
		return (x > y) ? x : y;
	endfunction

	// attach a node to the model forest; bad requests leave it unchanged
	function automatic void forest_attach(int n, int p, logic [WEIGHT_W-1:0] w);
		int mid;
		if (n == 0 || depth_of[n] != 0 || p == n) return;
		if (p != 0 && depth_of[p] == 0) return;
		depth_of[n] = (p == 0) ? 1 : depth_of[p] + 1;
		lift_parent[n][0] = NODE_W'(p);
		lift_max[n][0] = (p == 0) ? '0 : w;
		for (int i = 1; i < LVLS; i++) begin
			mid = int'(lift_parent[n][i-1]);
			lift_parent[n][i] = lift_parent[mid][i-1];
			lift_max[n][i] = wmax(lift_max[n][i-1], lift_max[mid][i-1]);
		end
	endfunction

	function automatic answer_t path_answer(int a, int b);
		answer_t r;
		logic [WEIGHT_W-1:0] best;
		int t, up;
		r.lca = '0;
		r.pmax = '0;
		r.disc = 1'b1;
		best = '0;
		if (depth_of[a] == 0 || depth_of[b] == 0) return r;
		if (depth_of[a] < depth_of[b]) begin
			t = a; a = b; b = t;
		end
		for (int i = LVLS - 1; i >= 0; i--) begin
			up = int'(lift_parent[a][i]);
			if (depth_of[up] >= depth_of[b]) begin
				best = wmax(best, lift_max[a][i]);
				a = up;
			end
		end
		if (a != b) begin
			for (int i = LVLS - 1; i >= 0; i--) begin
				if (lift_parent[a][i] != lift_parent[b][i]) begin
					best = wmax(best, wmax(lift_max[a][i], lift_max[b][i]));
					a = int'(lift_parent[a][i]);
					b = int'(lift_parent[b][i]);
				end
			end
			if (a != b) begin
				best = wmax(best, wmax(lift_max[a][0], lift_max[b][0]));
				a = int'(lift_parent[a][0]);
			end
		end
		if (a == 0) return r;
		r.lca = NODE_W'(a);
		r.pmax = best;
		r.disc = 1'b0;
		return r;
	endfunction

	// mid-cycle copies of busy; results are sampled there as well
	always @(negedge clk) begin
		answer_t exp_r;
		busy_seen = busy;
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$display("%0t: unexpected result lca=%0d max=%h disc=%b", $time,
					common_ancestor, path_maximum, disconnected);
				failed = 1'b1;
			end else begin
				exp_r = pending_answers.pop_front();
				if (common_ancestor !== exp_r.lca) begin
					$display("%0t: common_ancestor expected %0d actual %0d", $time,
						exp_r.lca, common_ancestor);
					failed = 1'b1;
				end
				if (path_maximum !== exp_r.pmax) begin
					$display("%0t: path_maximum expected %h actual %h", $time,
						exp_r.pmax, path_maximum);
					failed = 1'b1;
				end
				if (disconnected !== exp_r.disc) begin
					$display("%0t: disconnected expected %b actual %b", $time,
						exp_r.disc, disconnected);
					failed = 1'b1;
				end
			end
		end
	end

	// mostly back to back, sometimes short gaps, rarely long ones
	task automatic idle_gap();
		int pick, len;
		pick = $urandom_range(0, 99);
		if (pick < 55) len = 0;
		else if (pick < 90) len = $urandom_range(1, 3);
		else len = $urandom_range(10, 40);
		if (len > 0) begin
			start <= 1'b0;
			repeat (len) @(posedge clk);
		end
	endtask

	// one command transfer; the model is updated when it is accepted
	task automatic issue(op_t kind, int a, int b, logic [WEIGHT_W-1:0] w);
		answer_t r;
		start <= 1'b1;
		op <= kind;
		first_node <= a[NODE_W-1:0];
		second_node <= b[NODE_W-1:0];
		edge_weight <= w;
		do @(posedge clk); while (busy_seen);
		if (kind == OP_ADD) begin
			forest_attach(a, b, w);
			r.lca = '0;
			r.pmax = '0;
			r.disc = 1'b0;
		end else begin
			r = path_answer(a, b);
		end
		pending_answers = {pending_answers, r};
		idle_gap();
	endtask

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) return $urandom();
		if (pick < 8) return $urandom_range(0, 15);
		if (pick < 9) return '0;
		return '1;
	endfunction

	task automatic test_directed();
		issue(OP_ADD, 1, 0, 32'hFFFF_FFFF);      // root, weight dropped
		issue(OP_ADD, 2, 1, 32'hFFFF_FFFF);
		issue(OP_ADD, 3, 1, 32'h0000_0000);
		issue(OP_ADD, 4, 3, 32'h5555_AAAA);
		issue(OP_QUERY, 2, 4, 32'h1234_5678);
		issue(OP_QUERY, 4, 4, 32'hFFFF_FFFF);     // equal nodes
		issue(OP_QUERY, 4, 1, 0);                 // ancestor pair
		issue(OP_QUERY, 0, 1, 0);                 // sentinel node
		issue(OP_QUERY, 1023, 2, 0);              // absent node
		issue(OP_ADD, 0, 1, 32'hAAAA_5555);      // node zero ignored
		issue(OP_ADD, 2, 3, 7);                   // duplicate ignored
		issue(OP_ADD, 5, 600, 7);                 // missing parent
		issue(OP_ADD, 5, 5, 7);                   // self parent
		issue(OP_ADD, 1023, 0, 9);                // second tree
		issue(OP_ADD, 512, 1023, 1);
		issue(OP_QUERY, 512, 2, 0);               // different trees
		issue(OP_QUERY, 512, 1023, 0);
		issue(OP_QUERY, 1, 1, 0);                 // root with itself
	endtask

	// well-formed growth with queries mixed in, plus some noise commands
	task automatic test_random_forest(int count);
		int a, b, pick;
		free_nodes.delete();
		for (int n = 1; n < NODES; n++)
			if (depth_of[n] == 0) free_nodes = {free_nodes, n};
		free_nodes.shuffle();
		placed_nodes.delete();
		for (int n = 1; n < NODES; n++)
			if (depth_of[n] != 0) placed_nodes = {placed_nodes, n};
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				issue(op_t'($urandom_range(0, 1)), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom());
			end else if (pick < 62 && free_nodes.size() > 0) begin
				a = free_nodes.pop_front();
				pick = $urandom_range(0, 9);
				if (pick == 0 || placed_nodes.size() == 0) b = 0;
				else if (pick < 6) b = placed_nodes[placed_nodes.size() - 1];
				else b = placed_nodes[$urandom_range(0, placed_nodes.size() - 1)];
				issue(OP_ADD, a, b, pick_weight());
				placed_nodes = {placed_nodes, a};
			end else if (placed_nodes.size() > 0) begin
				a = placed_nodes[$urandom_range(0, placed_nodes.size() - 1)];
				b = placed_nodes[$urandom_range(0, placed_nodes.size() - 1)];
				issue(OP_QUERY, a, b, $urandom());
			end
		end
	endtask

	task automatic test_random_queries(int count);
		int a, b;
		for (int k = 0; k < count; k++) begin
			a = placed_nodes[$urandom_range(0, placed_nodes.size() - 1)];
			if ($urandom_range(0, 9) == 0) b = a;
			else b = placed_nodes[$urandom_range(0, placed_nodes.size() - 1)];
			issue(OP_QUERY, a, b, $urandom());
		end
	endtask

	initial begin
		for (int n = 0; n < NODES; n++) begin
			depth_of[n] = 0;
			for (int i = 0; i < LVLS; i++) begin
				lift_parent[n][i] = '0;
				lift_max[n][i] = '0;
			end
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_forest(1150);
		test_random_queries(480);
		start <= 1'b0;
		while (pending_answers.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (!failed) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
